// ===== rtl/core/frp_pkg.sv =====
// Shared types, constants and the round function of the Feistel range permutation.
// Used by frp_div, frp_seq, feistel_range_permutation_core and frp_checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package frp_pkg;

   localparam int INDEX_BITS_DEF = 48;
   localparam int FACTOR_W       = 26;
   localparam int PROD_W         = 2 * FACTOR_W;
   localparam int KEY_W          = 64;
   localparam int DIV_W          = 64;
   localparam int ROUND_W        = 6;
   localparam int CSR_IDX_W      = 3;
   localparam int WALK_LIMIT     = 4096;
   localparam int WALK_W         = $clog2(WALK_LIMIT);

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACT_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FACT_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_LIMIT, S_SPLIT, S_SPLIT_WAIT,
      S_MIX, S_RDIV, S_RWAIT, S_MUL, S_ADD
   } state_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] fact_a;
      logic [FACTOR_W-1:0] fact_b;
      logic [KEY_W-1:0]    key;
      logic [ROUND_W-1:0]  rounds;
   } cfg_type;

   typedef struct packed {
      logic                done;
      logic [DIV_W-1:0]    quot;
      logic [FACTOR_W-1:0] rem;
   } div_rsp_type;

   localparam logic [7:0] SUBST_TABLE [256] = '{
      8'h91,8'h58,8'hb3,8'h31,8'h6c,8'h33,8'hda,8'h88,8'h57,8'hdd,8'h8c,8'hf2,8'h29,8'h5a,8'h08,8'h9f,
      8'h49,8'h34,8'hce,8'h99,8'h9e,8'hbf,8'h0f,8'h81,8'hd4,8'h2f,8'h92,8'h3f,8'h95,8'hf5,8'h23,8'h00,
      8'h0d,8'h3e,8'ha8,8'h90,8'h98,8'hdd,8'h20,8'h00,8'h03,8'h69,8'h0a,8'hca,8'hba,8'h12,8'h08,8'h41,
      8'h6e,8'hb9,8'h86,8'he4,8'h50,8'hf0,8'h84,8'he2,8'hb3,8'hb3,8'hc8,8'hb5,8'hb2,8'h2d,8'h18,8'h70,
      8'h0a,8'hd7,8'h92,8'h90,8'h9e,8'h1e,8'h0c,8'h1f,8'h08,8'he8,8'h06,8'hfd,8'h85,8'h2f,8'haa,8'h5d,
      8'hcf,8'hf9,8'he3,8'h55,8'hb9,8'hfe,8'ha6,8'h7f,8'h44,8'h3b,8'h4a,8'h4f,8'hc9,8'h2f,8'hd2,8'hd3,
      8'h8e,8'hdc,8'hae,8'hba,8'h4f,8'h02,8'hb4,8'h76,8'hba,8'h64,8'h2d,8'h07,8'h9e,8'h08,8'hec,8'hbd,
      8'h52,8'h29,8'h07,8'hbb,8'h9f,8'hb5,8'h58,8'h6f,8'h07,8'h55,8'hb0,8'h34,8'h74,8'h9f,8'h05,8'hb2,
      8'hdf,8'ha9,8'hc6,8'h2a,8'ha3,8'h5d,8'hff,8'h10,8'h40,8'hb3,8'hb7,8'hb4,8'h63,8'h6e,8'hf4,8'h3e,
      8'hee,8'hf6,8'h49,8'h52,8'he3,8'h11,8'hb3,8'hf1,8'hfb,8'h60,8'h48,8'ha1,8'ha4,8'h19,8'h7a,8'h2e,
      8'h90,8'h28,8'h90,8'h8d,8'h5e,8'h8c,8'h8c,8'hc4,8'hf2,8'h4a,8'hf6,8'hb2,8'h19,8'h83,8'hea,8'hed,
      8'h6d,8'hba,8'hfe,8'hd8,8'hb6,8'ha3,8'h5a,8'hb4,8'h48,8'hfa,8'hbe,8'h5c,8'h69,8'hac,8'h3c,8'h8f,
      8'h63,8'haf,8'ha4,8'h42,8'h25,8'h50,8'hab,8'h65,8'h80,8'h65,8'hb9,8'hfb,8'hc7,8'hf2,8'h2d,8'h5c,
      8'he3,8'h4c,8'ha4,8'ha6,8'h8e,8'h07,8'h9c,8'heb,8'h41,8'h93,8'h65,8'h44,8'h4a,8'h86,8'hc1,8'hf6,
      8'h2c,8'h97,8'hfd,8'hf4,8'h6c,8'hdc,8'he1,8'he0,8'h28,8'hd9,8'h89,8'h7b,8'h09,8'he2,8'ha0,8'h38,
      8'h74,8'h4a,8'ha6,8'h5e,8'hd2,8'he2,8'h4d,8'hf3,8'hf4,8'hc6,8'hbc,8'ha2,8'h51,8'h58,8'he8,8'hae
   };

   // rnd is 1..63
   function automatic logic [KEY_W-1:0] round_mix(input logic [KEY_W-1:0] key,
                                                   input logic [ROUND_W-1:0] rnd,
                                                   input logic [FACTOR_W-1:0] half);
      logic [KEY_W-1:0] k;
      logic [KEY_W-1:0] h;
      logic [7:0]       s [8];
      logic [KEY_W-1:0] lo_pair;
      logic [KEY_W-1:0] hi_pair;
      logic [KEY_W-1:0] p2;
      logic [KEY_W-1:0] p3;
      k = key ^ {{(KEY_W-ROUND_W){1'b0}}, rnd};
      h = {{(KEY_W-FACTOR_W){1'b0}}, half}
          ^ (key << rnd) ^ (key >> (7'd64 - {1'b0, rnd}));
      for (int n = 0; n < 8; n++) begin
         s[n] = SUBST_TABLE[h[8*n +: 8] ^ k[7:0]];
      end
      lo_pair = {48'b0, s[1], s[0]};
      hi_pair = {32'b0, s[3], s[2], 16'b0};
      p2      = {48'b0, s[5], s[4]} << 23;
      p3      = {32'b0, s[7], s[6], 16'b0} << 33;
      return lo_pair ^ hi_pair ^ p2 ^ p3;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/frp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle: 64-bit dividend, 26-bit divisor.
// Depends on frp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frp_div
   import frp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_W-1:0]    dividend,
   input  wire logic [FACTOR_W-1:0] divisor,
   output      div_rsp_type         rsp
);

   localparam int CNT_W = $clog2(DIV_W);

   logic                run_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [DIV_W-1:0]    quo_ff;
   logic [FACTOR_W:0]   rem_ff;
   logic [FACTOR_W-1:0] dsr_ff;
   logic [FACTOR_W:0]   rem_sh;
   logic [FACTOR_W:0]   rem_in;
   logic                qbit;

   always_comb begin
      rem_sh = {rem_ff[FACTOR_W-1:0], quo_ff[DIV_W-1]};
      qbit   = rem_sh >= {1'b0, dsr_ff};
      rem_in = qbit ? rem_sh - {1'b0, dsr_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == CNT_W'(DIV_W - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         quo_ff <= {quo_ff[DIV_W-2:0], qbit};
         rem_ff <= rem_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff[FACTOR_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/frp_seq.sv =====
// Sequencer and datapath: split, Feistel rounds, recombine and cycle walk on a shared divider.
// Depends on frp_pkg and frp_div.
`timescale 1ns / 1ps
`default_nettype none
module frp_seq
   import frp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic                  mode,
   input  wire logic [INDEX_BITS-1:0] index,
   input  wire logic [INDEX_BITS:0]   range_size,
   input  wire cfg_type               cfg,
   output      logic                  busy,
   output      logic                  rsp_valid,
   output      logic [INDEX_BITS-1:0] rsp_permuted,
   output      logic                  rsp_out_of_range
);

   localparam int CMP_W = (INDEX_BITS + 1 > PROD_W) ? INDEX_BITS + 1 : PROD_W;

   state_type           state_ff, state_in;
   logic                inv_ff;
   logic [CMP_W-1:0]    idx_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   c_ff;
   logic [FACTOR_W-1:0] x_ff, y_ff;
   logic [ROUND_W-1:0]  j_ff;
   logic [KEY_W-1:0]    f_ff;
   logic [PROD_W-1:0]   mul_ff;
   logic [FACTOR_W-1:0] lo_ff;
   logic [WALK_W-1:0]   pass_ff;
   logic                valid_ff, oor_ff;
   logic [INDEX_BITS-1:0] perm_ff;

   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [FACTOR_W-1:0] div_divisor;
   div_rsp_type         div_rsp;

   logic [CMP_W-1:0]    range_ext, prod_ext, limit, c_next_ext;
   logic [PROD_W-1:0]   c_next;
   logic                f_gt_y, split_swap, last_round, hit, walk_end;
   logic [FACTOR_W-1:0] md, t_inv;

   frp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .rsp      (div_rsp)
   );

   always_comb begin
      range_ext  = CMP_W'(range_size);
      prod_ext   = CMP_W'(prod_ff);
      limit      = (range_ext < prod_ext) ? range_ext : prod_ext;
      c_next     = mul_ff + PROD_W'(lo_ff);
      c_next_ext = CMP_W'(c_next);
      hit        = c_next_ext < range_ext;
      walk_end   = pass_ff == WALK_W'(WALK_LIMIT - 1);
      f_gt_y     = f_ff > KEY_W'(y_ff);
      md         = j_ff[0] ? cfg.fact_a : cfg.fact_b;
      split_swap = inv_ff && cfg.rounds[0];
      last_round = inv_ff ? (j_ff == ROUND_W'(1)) : (j_ff == cfg.rounds);
      t_inv      = (f_gt_y && div_rsp.rem != '0) ? md - div_rsp.rem
                 : (f_gt_y ? '0 : div_rsp.rem);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (go) state_in = S_PROD;
         S_PROD:       state_in = S_LIMIT;
         S_LIMIT:      state_in = (idx_ff >= limit) ? S_IDLE : S_SPLIT;
         S_SPLIT:      state_in = S_SPLIT_WAIT;
         S_SPLIT_WAIT: begin
            if (div_rsp.done) state_in = (cfg.rounds == '0) ? S_MUL : S_MIX;
         end
         S_MIX:        state_in = S_RDIV;
         S_RDIV:       state_in = S_RWAIT;
         S_RWAIT: begin
            if (div_rsp.done) state_in = last_round ? S_MUL : S_MIX;
         end
         S_MUL:        state_in = S_ADD;
         S_ADD:        state_in = (hit || walk_end) ? S_IDLE : S_SPLIT;
         default:      state_in = S_IDLE;
      endcase
   end

   // outputs to the divider
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_W'(c_ff);
      div_divisor  = cfg.fact_a;
      case (state_ff)
         S_SPLIT: div_start = 1'b1;
         S_RDIV: begin
            div_start   = 1'b1;
            div_divisor = md;
            if (!inv_ff) div_dividend = KEY_W'(x_ff) + f_ff;
            else if (f_gt_y) div_dividend = f_ff - KEY_W'(y_ff);
            else div_dividend = KEY_W'(y_ff) - f_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == S_LIMIT && idx_ff >= limit)
                  || (state_ff == S_ADD && (hit || walk_end));
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               inv_ff <= mode;
               idx_ff <= CMP_W'(index);
            end
         end
         S_PROD: prod_ff <= PROD_W'(cfg.fact_a) * PROD_W'(cfg.fact_b);
         S_LIMIT: begin
            c_ff    <= idx_ff[PROD_W-1:0];
            pass_ff <= '0;
            perm_ff <= '0;
            oor_ff  <= 1'b1;
         end
         S_SPLIT_WAIT: begin
            if (div_rsp.done) begin
               if (split_swap) begin
                  y_ff <= div_rsp.rem;
                  x_ff <= div_rsp.quot[FACTOR_W-1:0];
               end else begin
                  x_ff <= div_rsp.rem;
                  y_ff <= div_rsp.quot[FACTOR_W-1:0];
               end
               j_ff <= inv_ff ? cfg.rounds : ROUND_W'(1);
            end
         end
         S_MIX: f_ff <= round_mix(cfg.key, j_ff, inv_ff ? x_ff : y_ff);
         S_RWAIT: begin
            if (div_rsp.done) begin
               if (inv_ff) begin
                  y_ff <= x_ff;
                  x_ff <= t_inv;
                  j_ff <= j_ff - 1'b1;
               end else begin
                  x_ff <= y_ff;
                  y_ff <= div_rsp.rem;
                  j_ff <= j_ff + 1'b1;
               end
            end
         end
         S_MUL: begin
            if (!inv_ff && cfg.rounds[0]) begin
               mul_ff <= PROD_W'(cfg.fact_a) * PROD_W'(x_ff);
               lo_ff  <= y_ff;
            end else begin
               mul_ff <= PROD_W'(cfg.fact_a) * PROD_W'(y_ff);
               lo_ff  <= x_ff;
            end
         end
         S_ADD: begin
            c_ff    <= c_next;
            pass_ff <= pass_ff + 1'b1;
            if (hit) begin
               perm_ff <= c_next_ext[INDEX_BITS-1:0];
               oor_ff  <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = valid_ff;
   assign rsp_permuted     = perm_ff;
   assign rsp_out_of_range = oor_ff;

endmodule
`default_nettype wire

// ===== rtl/core/feistel_range_permutation_core.sv =====
// Channel   | Ports                                        | Handshake
// request   | start, busy, req_mode, req_index             | taken when start && !busy
// response  | rsp_valid, rsp_permuted, rsp_out_of_range    | one-cycle strobe, no stall
// config    | csr_wr_en, csr_index, csr_wr_data            | written when csr_wr_en
// An in-range request makes P walk passes (P <= 4096), each a split and R rounds (R = the rounds CSR),
// all on the bit-serial divider shared by the split and every round.
// Out-of-range requests finish after the S_PROD and S_LIMIT states. busy is high from the cycle after start until
// the response strobe; a new request may start in the strobe cycle.
// Synchronous active-high reset clears control and loads register defaults.
// Top level; depends on frp_pkg and frp_seq.
`timescale 1ns / 1ps
`default_nettype none
module feistel_range_permutation_core
   import frp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic                  req_mode,
   input  wire logic [INDEX_BITS-1:0] req_index,
   output      logic                  rsp_valid,
   output      logic [INDEX_BITS-1:0] rsp_permuted,
   output      logic                  rsp_out_of_range,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [KEY_W-1:0]      csr_wr_data
);

   logic [INDEX_BITS:0] range_ff;
   cfg_type             cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff      <= (INDEX_BITS+1)'(1);
         cfg_ff.fact_a <= FACTOR_W'(1);
         cfg_ff.fact_b <= FACTOR_W'(2);
         cfg_ff.key    <= '0;
         cfg_ff.rounds <= ROUND_W'(14);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE:  range_ff      <= csr_wr_data[INDEX_BITS:0];
            CSR_FACT_A: cfg_ff.fact_a <= csr_wr_data[FACTOR_W-1:0];
            CSR_FACT_B: cfg_ff.fact_b <= csr_wr_data[FACTOR_W-1:0];
            CSR_KEY:    cfg_ff.key    <= csr_wr_data;
            CSR_ROUNDS: cfg_ff.rounds <= csr_wr_data[ROUND_W-1:0];
            default: ;
         endcase
      end
   end

   frp_seq #(.INDEX_BITS(INDEX_BITS)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .go               (start && !busy),
      .mode             (req_mode),
      .index            (req_index),
      .range_size       (range_ff),
      .cfg              (cfg_ff),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_permuted     (rsp_permuted),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule
`default_nettype wire

// ===== rtl/core/frp_checker.sv =====
// Port-level checks on feistel_range_permutation_core, bound to the top level.
// Depends on frp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frp_checker
   import frp_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_valid,
   input wire logic [INDEX_BITS-1:0] rsp_permuted,
   input wire logic                  rsp_out_of_range
);

   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back response strobes");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> rsp_permuted == '0)
      else $error("out-of-range response carries nonzero value");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request taken but not busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without a request in flight");

   a_busy_ends_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy dropped without a response");

endmodule

bind feistel_range_permutation_core frp_checker #(.INDEX_BITS(INDEX_BITS)) u_frp_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_permuted     (rsp_permuted),
   .rsp_out_of_range (rsp_out_of_range)
);
`default_nettype wire
